@@ rtl/atp_pkg.sv @@
// shared types, codes and helper functions of the address text parser
package atp_pkg;

  localparam int unsigned AddrWidth = 48;
  localparam int unsigned ByteLanes = AddrWidth / 8;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ST_DIGITS    = 3'd2;
  localparam logic [2:0] ST_SEPS      = 3'd3;
  localparam logic [2:0] ST_OVER      = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  // hex prefix tracking
  localparam logic [1:0] PP_NONE   = 2'd0;
  localparam logic [1:0] PP_ZERO   = 2'd1;
  localparam logic [1:0] PP_ZERO_X = 2'd2;
  localparam logic [1:0] PP_DIGITS = 2'd3;

  // group limits
  localparam logic [2:0] DEC_MAX_DIGITS = 3'd3;
  localparam logic [2:0] HEX_MAX_DIGITS = 3'd4;
  localparam logic [3:0] DEC_MAX_SEPS   = 4'd3;
  localparam logic [3:0] HEX_MAX_SEPS   = 4'd5;
  localparam logic [15:0] BYTE_MAX      = 16'd255;

  // characters
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_LA    = 8'h61;
  localparam logic [7:0] CHR_LF    = 8'h66;
  localparam logic [7:0] CHR_UA    = 8'h41;
  localparam logic [7:0] CHR_UF    = 8'h46;
  localparam logic [7:0] CHR_LX    = 8'h78;
  localparam logic [7:0] CHR_UX    = 8'h58;
  localparam logic [7:0] CHR_DOT   = 8'h2e;
  localparam logic [7:0] CHR_COLON = 8'h3a;

  typedef struct packed {
    logic [15:0]          group_value;
    logic [2:0]           digit_count;
    logic [2:0]           group_index;
    logic [AddrWidth-1:0] address_acc;
    logic [2:0]           error_code;
    logic [1:0]           prefix_phase;
    logic                 hex_stopped;
  } atp_state_t;

  typedef struct packed {
    logic [AddrWidth-1:0] address;
    logic [2:0]           group_total;
    logic [2:0]           status;
  } atp_result_t;

  // hex digit decode: {valid, value}
  function automatic logic [4:0] atp_hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CHR_ZERO && c <= CHR_NINE) begin
      r = {1'b1, 4'(c - CHR_ZERO)};
    end else if (c >= CHR_LA && c <= CHR_LF) begin
      r = {1'b1, 4'(c - CHR_LA + 8'd10)};
    end else if (c >= CHR_UA && c <= CHR_UF) begin
      r = {1'b1, 4'(c - CHR_UA + 8'd10)};
    end
    return r;
  endfunction

  // close the current group, the outcome lands in error_code
  function automatic atp_state_t atp_close(input atp_state_t s, input logic hex);
    atp_state_t r;
    logic [15:0] v;
    r = s;
    v = s.group_value;
    if (hex && s.prefix_phase != PP_DIGITS) begin
      v = 16'd0;
    end
    if (s.digit_count == 3'd0) begin
      r.error_code = ST_EMPTY;
    end else if (hex && s.prefix_phase == PP_NONE) begin
      r.error_code = ST_EMPTY;
    end else if (v > BYTE_MAX) begin
      r.error_code = ST_OVER;
    end else begin
      for (int k = 0; k < ByteLanes; k++) begin
        if (s.group_index == 3'(k)) begin
          r.address_acc[8*k +: 8] = s.address_acc[8*k +: 8] | v[7:0];
        end
      end
      r.group_index  = 3'(s.group_index + 3'd1);
      r.group_value  = 16'd0;
      r.digit_count  = 3'd0;
      r.prefix_phase = PP_NONE;
      r.hex_stopped  = 1'b0;
      r.error_code   = ST_OK;
    end
    return r;
  endfunction

endpackage

@@ rtl/atp_parse.sv @@
// per-character parse state register and its combinational update
module atp_parse import atp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  symbol_i,
  input  logic        last_i,
  input  logic        hex_i,
  output atp_result_t result_o
);

  atp_state_t state_q, state_d;
  atp_state_t n;
  logic [4:0] hv;
  logic       is_x;
  logic       member;
  logic [7:0] sep;
  logic [2:0] max_dig;
  logic [3:0] max_sep;
  logic [15:0] dec_val;
  logic [15:0] dig_val;

  always_comb begin
    n       = state_q;
    hv      = atp_hex_val(symbol_i);
    is_x    = (symbol_i == CHR_LX) || (symbol_i == CHR_UX);
    member  = hex_i ? (hv[4] || is_x) : (symbol_i >= CHR_ZERO && symbol_i <= CHR_NINE);
    sep     = hex_i ? CHR_COLON : CHR_DOT;
    max_dig = hex_i ? HEX_MAX_DIGITS : DEC_MAX_DIGITS;
    max_sep = hex_i ? HEX_MAX_SEPS : DEC_MAX_SEPS;
    dig_val = {12'd0, hv[3:0]};
    dec_val = 16'((state_q.group_value << 3) + (state_q.group_value << 1) + dig_val);

    if (state_q.error_code == ST_OK) begin
      if (member) begin
        n.digit_count = 3'(state_q.digit_count + 3'd1);
        if (n.digit_count > max_dig) begin
          n.error_code = ST_DIGITS;
        end else if (!hex_i) begin
          n.group_value = dec_val;
        end else if (!state_q.hex_stopped) begin
          case (state_q.prefix_phase)
            PP_NONE: begin
              if (is_x) begin
                n.hex_stopped = 1'b1;
              end else if (symbol_i == CHR_ZERO) begin
                n.prefix_phase = PP_ZERO;
                n.group_value  = 16'd0;
              end else begin
                n.prefix_phase = PP_DIGITS;
                n.group_value  = dig_val;
              end
            end
            PP_ZERO: begin
              if (is_x) begin
                n.prefix_phase = PP_ZERO_X;
              end else begin
                n.prefix_phase = PP_DIGITS;
                n.group_value  = dig_val;
              end
            end
            PP_ZERO_X: begin
              n.prefix_phase = PP_DIGITS;
              if (is_x) begin
                n.hex_stopped = 1'b1;
                n.group_value = 16'd0;
              end else begin
                n.group_value = dig_val;
              end
            end
            default: begin
              if (is_x) begin
                n.hex_stopped = 1'b1;
              end else begin
                n.group_value = {state_q.group_value[11:0], hv[3:0]};
              end
            end
          endcase
        end
      end else if (symbol_i == sep) begin
        if (({1'b0, state_q.group_index} + 4'd1) > max_sep) begin
          n.error_code = ST_SEPS;
        end else begin
          n = atp_close(state_q, hex_i);
        end
      end else begin
        n.error_code = ST_BAD_CHAR;
      end
    end

    if (last_i && n.error_code == ST_OK) begin
      n = atp_close(n, hex_i);
    end

    result_o.address     = n.address_acc;
    result_o.group_total = n.group_index;
    result_o.status      = n.error_code;

    state_d = state_q;
    if (step_i) begin
      state_d = last_i ? '0 : n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (state_q == '0))
    else $error("parse state not cleared after last character");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !last_i && state_q.error_code != ST_OK)
      |=> (state_q.error_code == $past(state_q.error_code)))
    else $error("error code changed before end of text");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.group_index <= 3'(ByteLanes - 1)))
    else $error("group index beyond the last byte lane");

endmodule

@@ rtl/address_text_parser.sv @@
// address text parser top level: stream ports, input and result registers
// Takes one ASCII character per clock on the slave stream while tready is
// high (tlast marks the end of the text) and, in the mode held in the
// configuration register (0 dotted decimal, 1 colon hex), builds the address
// bytes. A character passes an input register, and the combinational parse
// update of the final character is written into the result register, from
// which the result is presented. Only final characters need room in the
// result register, so a waiting result stalls the input stream only once the
// next final character reaches the parser.
module address_text_parser import atp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // symbol
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // address, group_total, status, zero pad
);

  logic        mode_q;
  logic        in_valid_q;
  logic [7:0]  symbol_q;
  logic        last_q;
  logic        out_valid_q;
  atp_result_t res_q;
  atp_result_t res;
  logic        adv;

  assign adv = in_valid_q && (!last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      symbol_q <= s_axis_tdata;
      last_q   <= s_axis_tlast;
    end
  end

  atp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .symbol_i (symbol_q),
    .last_i   (last_q),
    .hex_i    (mode_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.status, res_q.group_total, res_q.address};

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(adv && last_q))
    else $error("result raised without a final character");

  a_ok_has_groups: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.status == ST_OK) |-> (res_q.group_total != 3'd0))
    else $error("ok status with no stored group");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !(adv && last_q))
    else $error("pending result overwritten");

endmodule
